### rtl/qws_pkg.sv
// shared types and constants for the quoted word splitter
`timescale 1ns / 1ps

package qws_pkg;

    localparam int unsigned MaxFieldsDefault = 255;
    localparam int unsigned CharWidth        = 8;
    localparam int unsigned CountWidth       = 8;

    localparam logic [CharWidth-1:0] ChSquote = 8'h27;
    localparam logic [CharWidth-1:0] ChDquote = 8'h22;
    localparam logic [CharWidth-1:0] ChEscape = 8'h5C;
    localparam logic [CharWidth-1:0] ChSpace  = 8'h20;
    localparam logic [CharWidth-1:0] ChTab    = 8'h09;
    localparam logic [CharWidth-1:0] ChCr     = 8'h0D;

    typedef logic [CharWidth-1:0]  char_t;
    typedef logic [CountWidth-1:0] count_t;

    typedef struct packed {
        count_t fields_done;
        logic   single_quote_open;
        logic   double_quote_open;
        logic   escape_pending;
        logic   verbatim_mode;
        logic   field_open;
        count_t verbatim_target;
        logic   at_line_start;
    } parse_state_t;

    typedef struct packed {
        logic   close_before;
        logic   char_valid;
        char_t  out_char;
        count_t char_field;
        logic   close_after;
        logic   line_done;
        count_t field_count;
    } parse_result_t;

    function automatic logic is_blank(input char_t c);
        is_blank = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
    endfunction

endpackage

### rtl/qws_if.sv
// valid/ready channel interfaces for input bytes and parse results
`timescale 1ns / 1ps

interface qws_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       line_last;
    logic [7:0] verbatim_field;

    modport source (output valid, output in_byte, output line_last,
                    output verbatim_field, input ready);
    modport sink   (input valid, input in_byte, input line_last,
                    input verbatim_field, output ready);
endinterface

interface qws_out_if;
    logic       valid;
    logic       ready;
    logic       close_before;
    logic       char_valid;
    logic [7:0] out_char;
    logic [7:0] char_field;
    logic       close_after;
    logic       line_done;
    logic [7:0] field_count;

    modport source (output valid, output close_before, output char_valid,
                    output out_char, output char_field, output close_after,
                    output line_done, output field_count, input ready);
    modport sink   (input valid, input close_before, input char_valid,
                    input out_char, input char_field, input close_after,
                    input line_done, input field_count, output ready);
endinterface

### rtl/qws_step.sv
// next-state and result logic for one byte of the line
`timescale 1ns / 1ps

module qws_step #(
    parameter int unsigned MAX_FIELDS = qws_pkg::MaxFieldsDefault
) (
    input  qws_pkg::parse_state_t  cur,
    input  qws_pkg::char_t         in_byte,
    input  logic                   line_last,
    input  qws_pkg::count_t        verbatim_field,
    output qws_pkg::parse_state_t  nxt,
    output qws_pkg::parse_result_t res
);
    import qws_pkg::*;

    localparam count_t MaxCount = count_t'(MAX_FIELDS);

    parse_state_t s;
    logic         blank;
    logic         close_before;
    logic         char_valid;
    logic         close_after;

    always_comb
    begin
        s = cur;
        if (cur.at_line_start)
        begin
            s.fields_done       = '0;
            s.single_quote_open = 1'b0;
            s.double_quote_open = 1'b0;
            s.escape_pending    = 1'b0;
            s.verbatim_mode     = 1'b0;
            s.field_open        = 1'b0;
            s.verbatim_target   = verbatim_field;
            s.at_line_start     = 1'b0;
        end

        blank        = is_blank(in_byte);
        close_before = 1'b0;
        char_valid   = 1'b0;
        close_after  = 1'b0;

        // separator or field start
        if (!s.verbatim_mode && s.field_open && blank && !s.single_quote_open &&
            !s.double_quote_open && !s.escape_pending)
        begin
            close_before = 1'b1;
            s.field_open = 1'b0;
            if (s.fields_done < MaxCount)
            begin
                s.fields_done = s.fields_done + count_t'(1);
            end
            if ((s.verbatim_target < MaxCount) && (s.fields_done == s.verbatim_target))
            begin
                s.verbatim_mode = 1'b1;
                s.field_open    = 1'b1;
            end
        end
        else if (!s.verbatim_mode && !s.field_open)
        begin
            if ((s.verbatim_target < MaxCount) && (s.fields_done == s.verbatim_target))
            begin
                s.verbatim_mode = 1'b1;
                s.field_open    = 1'b1;
            end
            else if (!blank)
            begin
                s.field_open = 1'b1;
            end
        end

        // quote and escape handling
        if (s.verbatim_mode)
        begin
            char_valid = 1'b1;
        end
        else if (s.field_open && !close_before)
        begin
            if (s.escape_pending)
            begin
                s.escape_pending = 1'b0;
                char_valid       = 1'b1;
            end
            else if (s.single_quote_open)
            begin
                if (in_byte == ChSquote)
                begin
                    s.single_quote_open = 1'b0;
                end
                else
                begin
                    char_valid = 1'b1;
                end
            end
            else if (s.double_quote_open)
            begin
                if (in_byte == ChDquote)
                begin
                    s.double_quote_open = 1'b0;
                end
                else
                begin
                    char_valid = 1'b1;
                end
            end
            else if (in_byte == ChSquote)
            begin
                s.single_quote_open = 1'b1;
            end
            else if (in_byte == ChDquote)
            begin
                s.double_quote_open = 1'b1;
            end
            else if (in_byte == ChEscape)
            begin
                s.escape_pending = 1'b1;
            end
            else
            begin
                char_valid = 1'b1;
            end
        end

        res.char_field = char_valid ? s.fields_done : '0;
        res.out_char   = char_valid ? in_byte : '0;

        // end of line closes any open field
        if (line_last)
        begin
            if (s.field_open || (s.fields_done == '0))
            begin
                close_after = 1'b1;
                if (s.fields_done < MaxCount)
                begin
                    s.fields_done = s.fields_done + count_t'(1);
                end
            end
            s.field_open        = 1'b0;
            s.verbatim_mode     = 1'b0;
            s.single_quote_open = 1'b0;
            s.double_quote_open = 1'b0;
            s.escape_pending    = 1'b0;
            s.at_line_start     = 1'b1;
        end

        res.close_before = close_before;
        res.char_valid   = char_valid;
        res.close_after  = close_after;
        res.line_done    = line_last;
        res.field_count  = s.fields_done;
        nxt              = s;
    end

endmodule

### rtl/quoted_word_splitter_unit.sv
// top level of the quoted word splitter: parse state and result register
//
//   channel   dir   payload                                         transfer when
//   items     in    in_byte, line_last, verbatim_field              valid && ready
//   results   out   close_before, char_valid, out_char, char_field, valid && ready
//                   close_after, line_done, field_count
//
// one result per byte, one byte per cycle while the results channel is not stalled;
// the result is in the result register in the cycle after the input transfer
// items.ready stays high while the result register is empty or being drained
// rst_n clears the parse state and the result valid flag
// a stalled results channel holds the result and stops input after one byte
`timescale 1ns / 1ps

module quoted_word_splitter_unit #(
    parameter int unsigned MAX_FIELDS = qws_pkg::MaxFieldsDefault
) (
    input  logic      clk,
    input  logic      rst_n,
    qws_in_if.sink    items,
    qws_out_if.source results
);
    import qws_pkg::*;

    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t result_reg;
    parse_result_t result_next;
    logic          out_valid_reg;
    logic          in_xfer;

    qws_step #(
        .MAX_FIELDS(MAX_FIELDS)
    ) u_step (
        .cur           (state_reg),
        .in_byte       (items.in_byte),
        .line_last     (items.line_last),
        .verbatim_field(items.verbatim_field),
        .nxt           (state_next),
        .res           (result_next)
    );

    assign items.ready = !out_valid_reg || results.ready;
    assign in_xfer     = items.valid && items.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.fields_done       <= '0;
            state_reg.single_quote_open <= 1'b0;
            state_reg.double_quote_open <= 1'b0;
            state_reg.escape_pending    <= 1'b0;
            state_reg.verbatim_mode     <= 1'b0;
            state_reg.field_open        <= 1'b0;
            state_reg.verbatim_target   <= '1;
            state_reg.at_line_start     <= 1'b1;
            out_valid_reg               <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            result_reg <= result_next;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.close_before = result_reg.close_before;
    assign results.char_valid   = result_reg.char_valid;
    assign results.out_char     = result_reg.out_char;
    assign results.char_field   = result_reg.char_field;
    assign results.close_after  = result_reg.close_after;
    assign results.line_done    = result_reg.line_done;
    assign results.field_count  = result_reg.field_count;

endmodule
